/* rtl/assert_macros.svh */
// Assertion macros for the quaternion vector rotation RTL.
// Included by modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define QVR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define QVR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/qvr_pkg.sv */
// Shared types and constants for the quaternion vector rotation unit.
// No dependencies; imported by quaternion_vector_rotate_unit.
`default_nettype none

package qvr_pkg;

  // Quaternion components are always 16-bit signed fixed point.
  localparam int QUAT_WIDTH = 16;

  // Register stages from input to output register.
  localparam int STAGES = 5;

  typedef struct packed {
    logic signed [QUAT_WIDTH-1:0] w;
    logic signed [QUAT_WIDTH-1:0] x;
    logic signed [QUAT_WIDTH-1:0] y;
    logic signed [QUAT_WIDTH-1:0] z;
  } quat_t;

endpackage

`default_nettype wire

/* rtl/quaternion_vector_rotate_unit.sv */
// Quaternion vector rotation: r = q * (0,v) * conj(q), fixed point, pipelined.
// Depends on qvr_pkg and assert_macros.svh.
`default_nettype none

// quaternion_vector_rotate_unit
// Each item carries a quaternion q = (w,x,y,z) in signed Q1.QUAT_FRAC_BITS
// and a vector v of signed VEC_WIDTH-bit integers. The unit forms
// t = q * (0,v), rounds it half up by QUAT_FRAC_BITS, forms r = t * conj(q),
// rounds again and returns the vector part of r clipped to VEC_WIDTH bits;
// saturated_o flags an item in which any component was clipped. q is not
// normalized, so a non-unit q scales the result by |q|^2. Rate: one item
// per clock cycle sustained while out_stall_i is low. There are five
// register stages (product stage, sum-and-round stage, product stage,
// sum-and-round stage, saturate into the output register); the first loads
// at the accepting edge and items pass through the rest in that order.
// Every stage has its own valid bit and moves when the stage after it is
// empty or moving, so bubbles close up behind a stalled output and new items
// keep entering while a finished result waits. in_stall_o depends
// combinationally on out_stall_i through this ready chain. Internal sums are
// carried at full precision and wrap at 64 bits only for the widest
// parameter settings. The unit has no configuration and no state beyond
// the pipeline.
`include "assert_macros.svh"

module quaternion_vector_rotate_unit
  import qvr_pkg::*;
#(
  parameter int QUAT_FRAC_BITS = 14,
  parameter int VEC_WIDTH      = 24
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // input item channel
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire signed [QUAT_WIDTH-1:0] quat_w_i,
  input  wire signed [QUAT_WIDTH-1:0] quat_x_i,
  input  wire signed [QUAT_WIDTH-1:0] quat_y_i,
  input  wire signed [QUAT_WIDTH-1:0] quat_z_i,
  input  wire signed [VEC_WIDTH-1:0]  vec_x_i,
  input  wire signed [VEC_WIDTH-1:0]  vec_y_i,
  input  wire signed [VEC_WIDTH-1:0]  vec_z_i,
  // result item channel
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic signed [VEC_WIDTH-1:0] rot_x_o,
  output logic signed [VEC_WIDTH-1:0] rot_y_o,
  output logic signed [VEC_WIDTH-1:0] rot_z_o,
  output logic                        saturated_o
);

  // ---------------------------------------------------------------------------
  // Datapath widths. Products and sums are exact up to 64 bits and wrap beyond,
  // matching two's complement 64-bit arithmetic at the widest settings.
  // ---------------------------------------------------------------------------
  localparam int QW    = QUAT_WIDTH;
  localparam int QFB   = QUAT_FRAC_BITS;
  localparam int VW    = VEC_WIDTH;

  // first product q * (0,v)
  localparam int PW1R  = QW + VW;
  localparam int PW1   = (PW1R > 64) ? 64 : PW1R;
  localparam int AW1R  = ((QW + VW + 2) > (QFB + 2)) ? (QW + VW + 2) : (QFB + 2);
  localparam int AW1   = (AW1R > 64) ? 64 : AW1R;
  localparam int TW1   = AW1 - QFB;

  // second product t * conj(q)
  localparam int PW2R  = TW1 + QW;
  localparam int PW2   = (PW2R > 64) ? 64 : PW2R;
  localparam int AW2R  = ((TW1 + QW + 2) > (QFB + 2)) ? (TW1 + QW + 2) : (QFB + 2);
  localparam int AW2   = (AW2R > 64) ? 64 : AW2R;
  localparam int TW2   = AW2 - QFB;

  // saturation compare width
  localparam int EW    = (TW2 > VW) ? TW2 : VW;

  localparam logic signed [AW1-1:0] HALF1 =
    {{(AW1 - QFB){1'b0}}, 1'b1, {(QFB - 1){1'b0}}};
  localparam logic signed [AW2-1:0] HALF2 =
    {{(AW2 - QFB){1'b0}}, 1'b1, {(QFB - 1){1'b0}}};

  localparam logic signed [VW-1:0] OMAX = {1'b0, {(VW - 1){1'b1}}};
  localparam logic signed [VW-1:0] OMIN = {1'b1, {(VW - 1){1'b0}}};
  localparam logic signed [EW-1:0] EMAX = EW'(OMAX);
  localparam logic signed [EW-1:0] EMIN = EW'(OMIN);

  // ---------------------------------------------------------------------------
  // Pipeline control: one valid bit per stage, ready ripples back from output.
  // ---------------------------------------------------------------------------
  logic [STAGES-1:0] vld_q;
  logic [STAGES-1:0] vld_d;
  logic [STAGES-1:0] adv;
  logic [STAGES:0]   stg_rdy;

  always_comb begin
    stg_rdy[STAGES] = !out_stall_i;
    for (int k = STAGES - 1; k >= 0; k--) begin
      stg_rdy[k] = !vld_q[k] || stg_rdy[k+1];
    end
    for (int k = 0; k < STAGES; k++) begin
      if (k == 0) begin
        adv[k] = in_valid_i && stg_rdy[k];
      end else begin
        adv[k] = vld_q[k-1] && stg_rdy[k];
      end
      // load a new item, or hold the current one while the next stage is blocked
      vld_d[k] = adv[k] || (vld_q[k] && !stg_rdy[k+1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !stg_rdy[0];
  assign out_valid_o = vld_q[STAGES-1];

  // ---------------------------------------------------------------------------
  // Stage 0: the twelve products of q * (0,v).
  //   s0 = -x*vx - y*vy - z*vz
  //   s1 =  w*vx + y*vz - z*vy
  //   s2 =  w*vy - x*vz + z*vx
  //   s3 =  w*vz + x*vy - y*vx
  // ---------------------------------------------------------------------------
  quat_t                  q_in;
  logic signed [PW1-1:0]  p1_d [12];
  logic signed [PW1-1:0]  p1_q [12];
  quat_t                  q0_q;

  assign q_in = '{w: quat_w_i, x: quat_x_i, y: quat_y_i, z: quat_z_i};

  always_comb begin
    p1_d[0]  = PW1'(q_in.x) * PW1'(vec_x_i);
    p1_d[1]  = PW1'(q_in.y) * PW1'(vec_y_i);
    p1_d[2]  = PW1'(q_in.z) * PW1'(vec_z_i);
    p1_d[3]  = PW1'(q_in.w) * PW1'(vec_x_i);
    p1_d[4]  = PW1'(q_in.y) * PW1'(vec_z_i);
    p1_d[5]  = PW1'(q_in.z) * PW1'(vec_y_i);
    p1_d[6]  = PW1'(q_in.w) * PW1'(vec_y_i);
    p1_d[7]  = PW1'(q_in.x) * PW1'(vec_z_i);
    p1_d[8]  = PW1'(q_in.z) * PW1'(vec_x_i);
    p1_d[9]  = PW1'(q_in.w) * PW1'(vec_z_i);
    p1_d[10] = PW1'(q_in.x) * PW1'(vec_y_i);
    p1_d[11] = PW1'(q_in.y) * PW1'(vec_x_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      p1_q <= p1_d;
      q0_q <= q_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: sum, round half up and drop the fraction bits to form t.
  // ---------------------------------------------------------------------------
  logic signed [AW1-1:0] s1 [4];
  logic signed [AW1-1:0] rs1 [4];
  logic signed [TW1-1:0] t_d [4];
  logic signed [TW1-1:0] t_q [4];
  quat_t                 q1_q;

  always_comb begin
    s1[0] = -AW1'(p1_q[0]) - AW1'(p1_q[1])  - AW1'(p1_q[2]);
    s1[1] =  AW1'(p1_q[3]) + AW1'(p1_q[4])  - AW1'(p1_q[5]);
    s1[2] =  AW1'(p1_q[6]) - AW1'(p1_q[7])  + AW1'(p1_q[8]);
    s1[3] =  AW1'(p1_q[9]) + AW1'(p1_q[10]) - AW1'(p1_q[11]);
    for (int i = 0; i < 4; i++) begin
      rs1[i] = s1[i] + HALF1;
      t_d[i] = TW1'(rs1[i] >>> QFB);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      t_q  <= t_d;
      q1_q <= q0_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the twelve products of t * conj(q), signs folded into the sums.
  //   r1 = -t0*x + t1*w - t2*z + t3*y
  //   r2 = -t0*y + t1*z + t2*w - t3*x
  //   r3 = -t0*z - t1*y + t2*x + t3*w
  // ---------------------------------------------------------------------------
  logic signed [PW2-1:0] p2_d [12];
  logic signed [PW2-1:0] p2_q [12];

  always_comb begin
    p2_d[0]  = PW2'(t_q[0]) * PW2'(q1_q.x);
    p2_d[1]  = PW2'(t_q[1]) * PW2'(q1_q.w);
    p2_d[2]  = PW2'(t_q[2]) * PW2'(q1_q.z);
    p2_d[3]  = PW2'(t_q[3]) * PW2'(q1_q.y);
    p2_d[4]  = PW2'(t_q[0]) * PW2'(q1_q.y);
    p2_d[5]  = PW2'(t_q[1]) * PW2'(q1_q.z);
    p2_d[6]  = PW2'(t_q[2]) * PW2'(q1_q.w);
    p2_d[7]  = PW2'(t_q[3]) * PW2'(q1_q.x);
    p2_d[8]  = PW2'(t_q[0]) * PW2'(q1_q.z);
    p2_d[9]  = PW2'(t_q[1]) * PW2'(q1_q.y);
    p2_d[10] = PW2'(t_q[2]) * PW2'(q1_q.x);
    p2_d[11] = PW2'(t_q[3]) * PW2'(q1_q.w);
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      p2_q <= p2_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: sum, round half up, drop the fraction bits to form r.
  // ---------------------------------------------------------------------------
  logic signed [AW2-1:0] s2 [3];
  logic signed [AW2-1:0] rs2 [3];
  logic signed [TW2-1:0] r_d [3];
  logic signed [TW2-1:0] r_q [3];

  always_comb begin
    s2[0] = -AW2'(p2_q[0]) + AW2'(p2_q[1]) - AW2'(p2_q[2])  + AW2'(p2_q[3]);
    s2[1] = -AW2'(p2_q[4]) + AW2'(p2_q[5]) + AW2'(p2_q[6])  - AW2'(p2_q[7]);
    s2[2] = -AW2'(p2_q[8]) - AW2'(p2_q[9]) + AW2'(p2_q[10]) + AW2'(p2_q[11]);
    for (int i = 0; i < 3; i++) begin
      rs2[i] = s2[i] + HALF2;
      r_d[i] = TW2'(rs2[i] >>> QFB);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      r_q <= r_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: clip each component to the output range into the output register.
  // ---------------------------------------------------------------------------
  logic signed [EW-1:0] re [3];
  logic signed [VW-1:0] rot_d [3];
  logic [2:0]           clip;
  logic signed [VW-1:0] rot_q [3];
  logic                 sat_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      re[i] = EW'(r_q[i]);
      if (re[i] > EMAX) begin
        rot_d[i] = OMAX;
        clip[i]  = 1'b1;
      end else if (re[i] < EMIN) begin
        rot_d[i] = OMIN;
        clip[i]  = 1'b1;
      end else begin
        rot_d[i] = re[i][VW-1:0];
        clip[i]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      rot_q <= rot_d;
      sat_q <= |clip;
    end
  end

  assign rot_x_o     = rot_q[0];
  assign rot_y_o     = rot_q[1];
  assign rot_z_o     = rot_q[2];
  assign saturated_o = sat_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // some output component sits on a rail
  logic on_rail;

  assign on_rail = (rot_x_o == OMAX) || (rot_x_o == OMIN) || (rot_y_o == OMAX) ||
                   (rot_y_o == OMIN) || (rot_z_o == OMAX) || (rot_z_o == OMIN);

  // an accepted item must occupy the first stage on the next cycle
  `QVR_ASSERT_NEXT(a_in_lands, in_valid_i && !in_stall_o, vld_q[0], "accepted item lost at entry")
  // a full pipeline behind a stalled output must push back on the input
  `QVR_ASSERT(a_full_backpressure, ((&vld_q) && out_stall_i) |-> in_stall_o, "no backpressure")
  // a blocked middle stage must keep its item
  `QVR_ASSERT_NEXT(a_mid_hold, vld_q[2] && !stg_rdy[3], vld_q[2], "blocked stage dropped its item")
  // a clipped result must sit on a rail in some component
  `QVR_ASSERT(a_sat_rail, (out_valid_o && saturated_o) |-> on_rail, "saturated without rail")

endmodule

`default_nettype wire
